/* rtl/swr_pkg.sv */
`default_nettype none

package swr_pkg;

    // Stack geometry
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths on the ports
    localparam int ID_W      = 10;
    localparam int OP_W      = 2;
    localparam int ST_W      = 2;
    localparam int OUT_CNT_W = 5;

    // Opcodes
    localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OP_W-1:0] OP_POP    = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    // Control broadcast to every cell of the chain
    typedef struct packed {
        logic            push;
        logic            shift;
        logic [ID_W-1:0] key;
    } cell_ctrl_t;

endpackage

`default_nettype wire

/* rtl/swr_cell.sv */
`default_nettype none

module swr_cell (
    input  wire                      aclk,
    input  wire swr_pkg::cell_ctrl_t ctrl,
    input  wire                      occ,
    input  wire                      occ_dn,
    input  wire [swr_pkg::ID_W-1:0]  up_data,
    input  wire                      match_in,
    output logic                     match_out,
    input  wire [swr_pkg::ID_W-1:0]  top_in,
    output logic [swr_pkg::ID_W-1:0] top_out,
    output logic [swr_pkg::ID_W-1:0] data_out
);
    import swr_pkg::*;

    logic [ID_W-1:0] data_reg;
    logic            own_match;

    // Flag a held entry equal to the key; pass the prefix up the chain
    assign own_match = occ && (data_reg == ctrl.key);
    assign match_out = match_in || own_match;

    // Highest occupied entry wins on the way up
    assign top_out  = occ ? data_reg : top_in;
    assign data_out = data_reg;

    // Close the gap above a match, or take a pushed word at the free slot
    always_ff @(posedge aclk) begin
        if (ctrl.shift && match_out) begin
            data_reg <= up_data;
        end else if (ctrl.push && !occ && occ_dn) begin
            data_reg <= ctrl.key;
        end
    end

endmodule

`default_nettype wire

/* rtl/stack_with_remove_by_value.sv */
`default_nettype none

// Channel  Dir  tdata                                  tuser
// s_       in   car_id[9:0], zero pad to 16 bits        opcode[1:0]
// m_       out  removed_count[4:0], occupancy[9:5],     status[1:0]
//               top_id[19:10], zero pad to 24 bits
//
// One word is taken at a time; the next is not taken until the last result has
// been loaded into the result register. Push, pop and unused opcodes go straight
// to S_RESULT; remove first passes S_REMOVE, where the cell chain closes one gap
// per cycle until no match is left. While a result waits on m_tready, one more
// word is taken and the input then stalls until the result register frees. aresetn
// clears the fill count and the handshake; cell contents are unknown until pushed.

module stack_with_remove_by_value (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [15:0] s_tdata,   // car_id[9:0]
    input  wire  [1:0]  s_tuser,   // opcode[1:0]
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [23:0] m_tdata,   // removed_count[4:0], occupancy[9:5], top_id[19:10]
    output logic [1:0]  m_tuser    // status[1:0]
);
    import swr_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [ID_W-1:0]  key_reg, key_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [23:0]      m_tdata_reg;
    logic [1:0]       m_tuser_reg;

    logic             s_accept;
    logic             out_free;
    logic             full;
    logic             any_match;
    logic [ID_W-1:0]  in_id;
    logic [OP_W-1:0]  in_op;
    cell_ctrl_t       ctrl;

    logic [DEPTH-1:0] occ;
    logic [DEPTH:0]   match_chain;
    logic [ID_W-1:0]  top_chain [DEPTH+1];
    logic [ID_W-1:0]  cell_data [DEPTH];

    assign in_id    = s_tdata[ID_W-1:0];
    assign in_op    = s_tuser;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign full     = (fill_reg == CNT_W'(DEPTH));

    // Broadcast control to the chain
    assign ctrl.push  = s_accept && (in_op == OP_PUSH) && !full;
    assign ctrl.shift = (state_reg == S_REMOVE);
    assign ctrl.key   = (state_reg == S_IDLE) ? in_id : key_reg;

    assign match_chain[0] = 1'b0;
    assign top_chain[0]   = '0;
    assign any_match      = match_chain[DEPTH];

    // Build the row of cells
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic            occ_dn_w;
        logic [ID_W-1:0] up_w;

        assign occ[i] = (fill_reg > CNT_W'(i));
        if (i == 0) begin : g_bottom
            assign occ_dn_w = 1'b1;
        end else begin : g_mid
            assign occ_dn_w = occ[i-1];
        end
        if (i == DEPTH - 1) begin : g_top
            assign up_w = cell_data[i];
        end else begin : g_below
            assign up_w = cell_data[i+1];
        end

        swr_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occ       (occ[i]),
            .occ_dn    (occ_dn_w),
            .up_data   (up_w),
            .match_in  (match_chain[i]),
            .match_out (match_chain[i+1]),
            .top_in    (top_chain[i]),
            .top_out   (top_chain[i+1]),
            .data_out  (cell_data[i])
        );
    end

    // Sequence one word at a time
    always_comb begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        key_next      = key_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept) begin
                    removed_next = '0;
                    status_next  = ST_OK;
                    key_next     = in_id;
                    state_next   = S_RESULT;
                    case (in_op)
                        OP_PUSH: begin
                            if (full) begin
                                status_next = ST_FULL;
                            end else begin
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        OP_POP: begin
                            if (fill_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                fill_next    = fill_reg - CNT_W'(1);
                                removed_next = CNT_W'(1);
                            end
                        end
                        OP_REMOVE: state_next = S_REMOVE;
                        default: ;
                    endcase
                end
            end
            S_REMOVE: begin
                // Drop the lowest match each cycle until none is left
                if (any_match) begin
                    fill_next    = fill_reg - CNT_W'(1);
                    removed_next = removed_reg + CNT_W'(1);
                end else begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            fill_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload: hold the result until taken
    always_ff @(posedge aclk) begin
        removed_reg <= removed_next;
        status_reg  <= status_next;
        key_reg     <= key_next;
        if (state_reg == S_RESULT && out_free) begin
            m_tdata_reg <= {4'd0, top_chain[DEPTH], OUT_CNT_W'(fill_reg),
                            OUT_CNT_W'(removed_reg)};
            m_tuser_reg <= status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // Checks
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(DEPTH))
        else $error("fill count above depth");

    a_remove_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REMOVE && !any_match) |=> (state_reg == S_RESULT))
        else $error("remove did not finish when no match was left");

    a_remove_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_REMOVE && any_match) |=> (fill_reg == $past(fill_reg) - CNT_W'(1)))
        else $error("remove step did not drop one entry");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != S_IDLE))
        else $error("accepted word produced no work");

    a_result_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_RESULT && out_free) |=> m_tvalid_reg)
        else $error("result not presented");

endmodule

`default_nettype wire

/* tb/stack_with_remove_by_value_tb.sv */
`timescale 1ns / 100ps

module stack_with_remove_by_value_tb;
    import swr_pkg::*;

    // Opcode that the block must treat as a no-op
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    localparam int RANDOM_ITEMS = 1000;
    localparam int HOLD_LEN     = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 10;

    typedef struct {
        logic [OP_W-1:0] opcode;
        logic [ID_W-1:0] car_id;
    } stack_cmd_t;

    typedef struct {
        logic [ST_W-1:0]      status;
        logic [OUT_CNT_W-1:0] removed;
        logic [OUT_CNT_W-1:0] occupancy;
        logic [ID_W-1:0]      top_id;
    } stack_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // car_id[9:0]
    logic [1:0]  s_tuser  = '0;   // opcode[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;         // removed_count[4:0], occupancy[9:5], top_id[19:10]
    logic [1:0]  m_tuser;         // status[1:0]

    stack_cmd_t    pending_words[$];
    stack_result_t expected_results[$];

    // Shadow copy of the stack
    logic [ID_W-1:0] model_stack [DEPTH];
    int              model_fill = 0;

    bit in_fire     = 1'b0;
    int in_count    = 0;
    int err_count   = 0;
    int idle_cycles = 0;
    bit hold_req    = 1'b0;
    bit hold_done   = 1'b0;
    int hold_cycles = 0;
    bit no_idle;

    stack_with_remove_by_value dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 aclk = ~aclk;

    // Stretch of input words during which neither side idles
    assign no_idle = (in_count >= 500) && (in_count < 700);

    // Apply one command to the shadow stack and build the word it should produce
    task automatic apply_stack_op(input stack_cmd_t cmd, output stack_result_t res);
        int keep;
        res.status  = ST_OK;
        res.removed = '0;
        case (cmd.opcode)
            OP_PUSH: begin
                if (model_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    model_stack[model_fill] = cmd.car_id;
                    model_fill++;
                end
            end
            OP_POP: begin
                if (model_fill == 0) begin
                    res.status = ST_EMPTY;
                end else begin
                    model_fill--;
                    res.removed = 1;
                end
            end
            OP_REMOVE: begin
                // compact the survivors toward the bottom, keeping their order
                keep = 0;
                for (int i = 0; i < model_fill; i++) begin
                    if (model_stack[i] == cmd.car_id) begin
                        res.removed++;
                    end else begin
                        model_stack[keep] = model_stack[i];
                        keep++;
                    end
                end
                model_fill = keep;
            end
            default: ;
        endcase
        res.occupancy = OUT_CNT_W'(model_fill);
        res.top_id    = (model_fill == 0) ? '0 : model_stack[model_fill - 1];
    endtask

    task automatic report_mismatch(input string what, input stack_result_t exp_res,
                                   input stack_result_t got);
        err_count++;
        if (err_count <= MAX_REPORTS) begin
            $display("%0t: %s: expected st=%0d rm=%0d occ=%0d top=%0d, got st=%0d rm=%0d occ=%0d top=%0d",
                     $time, what, exp_res.status, exp_res.removed, exp_res.occupancy,
                     exp_res.top_id, got.status, got.removed, got.occupancy, got.top_id);
        end
    endtask

    function automatic logic [ID_W-1:0] pick_id();
        case ($urandom_range(0, 9))
            0, 1:    pick_id = ID_W'($urandom_range(0, 1023));
            2:       pick_id = ID_W'($urandom_range(1000, 1023));
            default: pick_id = ID_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic queue_word(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
        stack_cmd_t cmd;
        cmd.opcode = op;
        cmd.car_id = id;
        pending_words.push_back(cmd);
    endtask

    // Random words in runs of 20, each run biased toward filling, draining or removing, or mixed
    task automatic queue_random(input int count);
        int mode;
        int roll;
        logic [OP_W-1:0] op;
        mode = 0;
        for (int n = 0; n < count; n++) begin
            if (n % 20 == 0) mode = $urandom_range(0, 3);
            roll = $urandom_range(0, 99);
            case (mode)
                0:       op = (roll < 70) ? OP_PUSH : (roll < 80) ? OP_POP :
                              (roll < 95) ? OP_REMOVE : OP_SPARE;
                1:       op = (roll < 60) ? OP_POP : (roll < 80) ? OP_PUSH :
                              (roll < 95) ? OP_REMOVE : OP_SPARE;
                2:       op = (roll < 50) ? OP_PUSH : (roll < 95) ? OP_REMOVE :
                              (roll < 98) ? OP_POP : OP_SPARE;
                default: op = (roll < 40) ? OP_PUSH : (roll < 70) ? OP_POP :
                              (roll < 95) ? OP_REMOVE : OP_SPARE;
            endcase
            queue_word(op, pick_id());
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_results.size() != 0) @(posedge aclk);
    endtask

    // Input driver: hold a word until taken, then advance
    always @(negedge aclk) begin : drive_input
        logic        next_valid;
        logic [15:0] next_data;
        logic [1:0]  next_user;
        next_valid = s_tvalid;
        next_data  = s_tdata;
        next_user  = s_tuser;
        if (aresetn) begin
            if (s_tvalid && in_fire) begin
                void'(pending_words.pop_front());
                next_valid = 1'b0;
            end
            if (!next_valid && pending_words.size() != 0 &&
                (no_idle || $urandom_range(0, 99) >= 25)) begin
                next_valid = 1'b1;
                next_data  = {6'b0, pending_words[0].car_id};
                next_user  = pending_words[0].opcode;
            end
        end
        s_tvalid <= next_valid;
        s_tdata  <= next_data;
        s_tuser  <= next_user;
    end

    // Result receiver: random stalls, plus one long hold-off on request
    always @(negedge aclk) begin : drive_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            m_tready <= 1'b0;
            hold_cycles++;
            if (hold_cycles >= HOLD_LEN) hold_done = 1'b1;
        end else begin
            m_tready <= no_idle || ($urandom_range(0, 99) >= 25);
        end
    end

    // Sample both channels, predict on each taken word, check each result word
    always @(posedge aclk) begin : monitor
        stack_cmd_t    cmd;
        stack_result_t exp_res;
        stack_result_t got;
        bit            out_fire;
        in_fire  = aresetn && s_tvalid && s_tready;
        out_fire = aresetn && m_tvalid && m_tready;
        if (in_fire) begin
            cmd.opcode = s_tuser;
            cmd.car_id = s_tdata[ID_W-1:0];
            apply_stack_op(cmd, exp_res);
            expected_results.push_back(exp_res);
            in_count++;
        end
        if (out_fire) begin
            got.status    = m_tuser;
            got.removed   = m_tdata[4:0];
            got.occupancy = m_tdata[9:5];
            got.top_id    = m_tdata[19:10];
            if (expected_results.size() == 0) begin
                exp_res = '{default: '0};
                report_mismatch("unexpected result", exp_res, got);
            end else begin
                exp_res = expected_results.pop_front();
                if (got.status !== exp_res.status || got.removed !== exp_res.removed ||
                    got.occupancy !== exp_res.occupancy || got.top_id !== exp_res.top_id)
                    report_mismatch("result mismatch", exp_res, got);
            end
        end
        // watchdog on cycles with work outstanding and nothing moving
        if (in_fire || out_fire) begin
            idle_cycles = 0;
        end else if (pending_words.size() != 0 || expected_results.size() != 0) begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Empty-stack corner cases
        queue_word(OP_POP, 10'd0);
        queue_word(OP_SPARE, 10'd1023);
        queue_word(OP_REMOVE, 10'd0);
        // Fill to capacity with extreme ids
        queue_word(OP_PUSH, 10'd1023);
        queue_word(OP_PUSH, 10'd0);
        queue_word(OP_PUSH, 10'd1000);
        queue_word(OP_PUSH, 10'd5);
        queue_word(OP_PUSH, 10'd1023);
        queue_word(OP_PUSH, 10'd999);
        queue_word(OP_PUSH, 10'd0);
        queue_word(OP_PUSH, 10'd1023);
        queue_word(OP_PUSH, 10'd512);
        queue_word(OP_PUSH, 10'd1023);
        queue_word(OP_PUSH, 10'd341);
        queue_word(OP_PUSH, 10'd682);
        queue_word(OP_PUSH, 10'd1023);
        queue_word(OP_PUSH, 10'd7);
        queue_word(OP_PUSH, 10'd1000);
        queue_word(OP_PUSH, 10'd1023);
        // Full-stack corner cases, then removals with many and no matches
        queue_word(OP_PUSH, 10'd3);
        queue_word(OP_SPARE, 10'd0);
        queue_word(OP_REMOVE, 10'd1023);
        queue_word(OP_REMOVE, 10'd77);
        queue_word(OP_POP, 10'd1023);
        queue_word(OP_REMOVE, 10'd1000);

        // Sender pauses here until every result is back
        wait_drained();

        // Long receiver hold-off while words keep coming
        hold_req = 1'b1;
        queue_random(RANDOM_ITEMS / 2);
        wait_drained();
        queue_random(RANDOM_ITEMS - RANDOM_ITEMS / 2);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (err_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
rtl/swr_pkg.sv
rtl/swr_cell.sv
rtl/stack_with_remove_by_value.sv
tb/stack_with_remove_by_value_tb.sv
